@@ hdl/dtg_pkg.sv @@
// Shared types and constants for the decimal entry tone generator.
// No dependencies; used by dtg_div and decimal_entry_tone_generator.
`default_nettype none

package dtg_pkg;

  // Width of frequency, half period and register data.
  localparam int FieldW = 20;
  localparam int CntW   = $clog2(FieldW);

  // Digits per frequency entry.
  localparam int DigitCount = 6;
  localparam int PosW       = 3;

  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] AsciiNine = 8'd57;

  localparam logic [FieldW-1:0] FieldMax     = {FieldW{1'b1}};
  localparam logic [FieldW-1:0] MaxFreqReset = FieldW'(500000);
  localparam logic [FieldW-1:0] NumerReset   = FieldW'(500000);

  localparam int CfgIdxW = 8;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegMaxFreq = CfgIdxW'(0);
  localparam cfg_idx_t RegNumer   = CfgIdxW'(1);

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StDiv
  } dtg_state_e;

endpackage

`default_nettype wire

@@ hdl/dtg_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dtg_pkg for the field width.
`default_nettype none

module dtg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [dtg_pkg::FieldW-1:0]    numer_i,
  input  wire logic [dtg_pkg::FieldW-1:0]    denom_i,
  output logic                               done_o,
  output logic [dtg_pkg::FieldW-1:0]         quot_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [dtg_pkg::CntW-1:0]      cnt_q;
  logic [dtg_pkg::FieldW-1:0]    rem_q;
  logic [dtg_pkg::FieldW-1:0]    nq_q;
  logic [dtg_pkg::FieldW-1:0]    den_q;
  logic [dtg_pkg::FieldW:0]      rem_sh;
  logic [dtg_pkg::FieldW:0]      rem_sub;
  logic                          qbit;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh  = {rem_q, nq_q[dtg_pkg::FieldW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = ~rem_sub[dtg_pkg::FieldW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == dtg_pkg::CntW'(dtg_pkg::FieldW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= numer_i;
      den_q <= denom_i;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[dtg_pkg::FieldW-1:0] : rem_sh[dtg_pkg::FieldW-1:0];
      nq_q  <= {nq_q[dtg_pkg::FieldW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

`default_nettype wire

@@ hdl/decimal_entry_tone_generator.sv @@
// Top level: decimal frequency entry, clamp, half period division and buzzer.
// Depends on dtg_pkg and dtg_div.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   func_i, rx_byte_i
//   out      source     out_valid_o/out_stall_i buzzer_level_o, report_valid_o,
//                                               frequency_hz_o, half_period_ticks_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick or a character that does not complete an entry gives its result in the
// cycle after the transfer. The last digit of an entry is clamped and registered,
// loads the divider, runs FieldW (20) quotient bits through the serial divider
// and then registers the result. One item is in work at a time; input stalls while
// a division runs or the result register is full and not being taken. Reset is
// asynchronous and needs no clearing pass; configuration writes are always taken.
`default_nettype none

module decimal_entry_tone_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [7:0]                    rx_byte_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               buzzer_level_o,
  output logic                               report_valid_o,
  output logic [dtg_pkg::FieldW-1:0]         frequency_hz_o,
  output logic [dtg_pkg::FieldW-1:0]         half_period_ticks_o,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire dtg_pkg::cfg_idx_t             cfg_index_i,
  input  wire logic [dtg_pkg::FieldW-1:0]    cfg_data_i
);

  localparam int W = dtg_pkg::FieldW;

  dtg_pkg::dtg_state_e state_q, state_d;

  logic [W-1:0]              max_freq_q;
  logic [W-1:0]              numer_q;
  logic [dtg_pkg::PosW-1:0]  pos_q;
  logic [W-1:0]              acc_q;
  logic [W-1:0]              half_q;
  logic [W-1:0]              tick_q;
  logic                      level_q;
  logic [W-1:0]              freq_q;

  logic                      out_valid_q;
  logic                      out_level_q;
  logic                      out_report_q;
  logic [W-1:0]              out_freq_q;
  logic [W-1:0]              out_half_q;

  logic                      in_xfer;
  logic                      div_start;
  logic                      div_done;
  logic [W-1:0]              div_quot;

  logic                      is_digit;
  logic [3:0]                digit;
  logic [W+3:0]              acc_x10;
  logic [W-1:0]              acc_sat;
  logic [W-1:0]              acc_next;
  logic [dtg_pkg::PosW-1:0]  pos_inc;
  logic                      entry_done;
  logic [W-1:0]              freq_clamp;
  logic [W-1:0]              freq_next;

  logic [W:0]                tick_inc;
  logic [W-1:0]              tick_d;
  logic                      level_d;

  // Digit accumulation: acc * 10 + digit as two shifted adds, saturated.
  always_comb begin
    is_digit   = (rx_byte_i >= dtg_pkg::AsciiZero) && (rx_byte_i <= dtg_pkg::AsciiNine);
    digit      = 4'(rx_byte_i - dtg_pkg::AsciiZero);
    acc_x10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{W{1'b0}}, digit};
    acc_sat    = (acc_x10[W+3:W] != 4'd0) ? dtg_pkg::FieldMax : acc_x10[W-1:0];
    acc_next   = (pos_q == '0) ? {{(W-4){1'b0}}, digit} : acc_sat;
    pos_inc    = pos_q + 1'b1;
    entry_done = is_digit && (pos_inc >= dtg_pkg::PosW'(dtg_pkg::DigitCount));
    freq_clamp = (acc_next > max_freq_q) ? max_freq_q : acc_next;
    freq_next  = (freq_clamp == '0) ? W'(1) : freq_clamp;
  end

  // Tick handling: toggle once half_q ticks have gone by; silent at zero.
  always_comb begin
    tick_inc = {1'b0, tick_q} + 1'b1;
    tick_d   = tick_q;
    level_d  = level_q;
    if (func_i) begin
      if (half_q == '0) begin
        tick_d  = '0;
        level_d = 1'b0;
      end else if (tick_inc >= {1'b0, half_q}) begin
        tick_d  = '0;
        level_d = ~level_q;
      end else begin
        tick_d = tick_inc[W-1:0];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      dtg_pkg::StIdle: begin
        in_stall_o = out_valid_q && out_stall_i;
        if (in_xfer && !func_i && entry_done) begin
          state_d = dtg_pkg::StStart;
        end
      end
      dtg_pkg::StStart: begin
        div_start = 1'b1;
        state_d   = dtg_pkg::StDiv;
      end
      dtg_pkg::StDiv: begin
        if (div_done) begin
          state_d = dtg_pkg::StIdle;
        end
      end
      default: state_d = dtg_pkg::StIdle;
    endcase
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  dtg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (numer_q),
    .denom_i (freq_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_freq_q  <= dtg_pkg::MaxFreqReset;
      numer_q     <= dtg_pkg::NumerReset;
      pos_q       <= '0;
      acc_q       <= '0;
      half_q      <= '0;
      tick_q      <= '0;
      level_q     <= 1'b0;
      freq_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dtg_pkg::RegMaxFreq: max_freq_q <= cfg_data_i;
          dtg_pkg::RegNumer:   numer_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the result once the downstream side takes it.
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        tick_q  <= tick_d;
        level_q <= level_d;
        if (!func_i && is_digit) begin
          acc_q <= acc_next;
          if (entry_done) begin
            pos_q  <= '0;
            freq_q <= freq_next;
          end else begin
            pos_q <= pos_inc;
          end
        end
        if (func_i || !entry_done) begin
          out_valid_q <= 1'b1;
        end
      end

      if (state_q == dtg_pkg::StDiv && div_done) begin
        half_q      <= div_quot;
        out_valid_q <= 1'b1;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (func_i || !entry_done)) begin
      out_level_q  <= level_d;
      out_report_q <= 1'b0;
      out_freq_q   <= freq_q;
      out_half_q   <= half_q;
    end else if (state_q == dtg_pkg::StDiv && div_done) begin
      out_level_q  <= level_q;
      out_report_q <= 1'b1;
      out_freq_q   <= freq_q;
      out_half_q   <= div_quot;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign buzzer_level_o      = out_level_q;
  assign report_valid_o      = out_report_q;
  assign frequency_hz_o      = out_freq_q;
  assign half_period_ticks_o = out_half_q;
  assign cfg_ready_o         = 1'b1;

endmodule

`default_nettype wire
